// ===== src/emca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_pkg
// Shared types, codes and constants of the excitable medium engine.
// ----------------------------------------------------------------------------
package emca_pkg;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_STEP  = 3'd2;
	localparam logic [2:0] MODE_PULSE = 3'd3;
	localparam logic [2:0] MODE_REST  = 3'd4;
	localparam logic [2:0] MODE_CLEAR = 3'd5;

	localparam logic [1:0] REG_NUM_STATES = 2'd0;
	localparam logic [1:0] REG_ROWS       = 2'd1;
	localparam logic [1:0] REG_COLS       = 2'd2;

	localparam logic [4:0] STATES_MIN   = 5'd5;
	localparam logic [4:0] STATES_MAX   = 5'd20;
	localparam logic [4:0] STATES_RESET = 5'd12;
	localparam logic [7:0] ROWS_RESET   = 8'd128;
	localparam logic [9:0] COLS_RESET   = 10'd512;

	// 3x7 block: row offsets 0..2 and column offsets 0..6 around the centre
	localparam logic [1:0] BLOCK_HALF_ROWS = 2'd1;
	localparam logic [2:0] BLOCK_HALF_COLS = 3'd3;
	localparam logic [1:0] BLOCK_LAST_ROW  = 2'd2;
	localparam logic [2:0] BLOCK_LAST_COL  = 3'd6;

	// neighbourhood read phases of a generation step
	localparam logic [2:0] PH_CENTRE = 3'd0;
	localparam logic [2:0] PH_UP     = 3'd1;
	localparam logic [2:0] PH_DOWN   = 3'd2;
	localparam logic [2:0] PH_LEFT   = 3'd3;
	localparam logic [2:0] PH_RIGHT  = 3'd4;
	localparam logic [2:0] PH_WRITE  = 3'd5;

	typedef enum logic [2:0] {
		ACT_IDLE, ACT_CLEAR, ACT_WRITE, ACT_READ,
		ACT_CAPTURE, ACT_STEP, ACT_PULSE, ACT_REST
	} dp_act_t;

	typedef struct packed {
		logic    load;
		dp_act_t act;
		logic    flip;
		logic    zero_bank;
		logic    post;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sweep_last;
		logic step_last;
		logic pulse_last;
	} dp_status_t;

	// (s+1) mod n for s up to 31 and n in 5..20: at most six subtractions
	function automatic logic [4:0] next_cool(input logic [4:0] s, input logic [4:0] n);
		logic [5:0] t;
		t = {1'b0, s} + 6'd1;
		for (int k = 0; k < 6; k++) begin
			if (t >= {1'b0, n}) begin
				t = t - {1'b0, n};
			end
		end
		return t[4:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/emca_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_req_if
// Request channel: one operation on the cell grid.
// ----------------------------------------------------------------------------
interface emca_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [6:0] row;
	logic [8:0] col;
	logic [4:0] cell_value;

	modport source (output valid, mode, row, col, cell_value, input ready);
	modport sink (input valid, mode, row, col, cell_value, output ready);
endinterface
`default_nettype wire

// ===== src/emca_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface emca_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] read_state;
	logic       op_done;

	modport source (output valid, read_state, op_done, input ready);
	modport sink (input valid, read_state, op_done, output ready);
endinterface
`default_nettype wire

// ===== src/emca_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module emca_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 65536
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/emca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_ctrl
// Operation sequencer: decodes requests, steps the datapath, posts results.
// ----------------------------------------------------------------------------
module emca_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [2:0]           in_mode,
	output      logic                 in_ready,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire emca_pkg::dp_status_t status,
	output      emca_pkg::dp_cmd_t    cmd
);
	typedef enum logic [9:0] {
		S_INIT  = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_WRITE = 10'b0000000100,
		S_READ  = 10'b0000001000,
		S_CAPT  = 10'b0000010000,
		S_STEP  = 10'b0000100000,
		S_PULSE = 10'b0001000000,
		S_REST  = 10'b0010000000,
		S_WIPE  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.act       = emca_pkg::ACT_IDLE;
		cmd.flip      = 1'b0;
		cmd.zero_bank = 1'b0;
		cmd.post      = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.act       = emca_pkg::ACT_CLEAR;
				cmd.zero_bank = 1'b1;
				if (status.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (in_mode)
						emca_pkg::MODE_WRITE: state_d = S_WRITE;
						emca_pkg::MODE_READ:  state_d = S_READ;
						emca_pkg::MODE_STEP:  state_d = S_STEP;
						emca_pkg::MODE_PULSE: state_d = S_PULSE;
						emca_pkg::MODE_REST:  state_d = S_REST;
						emca_pkg::MODE_CLEAR: state_d = S_WIPE;
						default:              state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.act = emca_pkg::ACT_WRITE;
				state_d = S_DONE;
			end
			S_READ: begin
				cmd.act = emca_pkg::ACT_READ;
				state_d = S_CAPT;
			end
			S_CAPT: begin
				cmd.act = emca_pkg::ACT_CAPTURE;
				state_d = S_DONE;
			end
			S_STEP: begin
				cmd.act = emca_pkg::ACT_STEP;
				if (status.step_last) begin
					cmd.flip = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_PULSE: begin
				cmd.act = emca_pkg::ACT_PULSE;
				if (status.pulse_last) state_d = S_DONE;
			end
			S_REST: begin
				cmd.act = emca_pkg::ACT_REST;
				if (status.sweep_last) state_d = S_DONE;
			end
			S_WIPE: begin
				cmd.act       = emca_pkg::ACT_CLEAR;
				cmd.zero_bank = 1'b1;
				if (status.clr_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.post) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/emca_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emca_dp
// Grid datapath: two cell banks, sweep counters, cell update and result.
// ----------------------------------------------------------------------------
module emca_dp #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 512
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire emca_pkg::dp_cmd_t    cmd,
	output      emca_pkg::dp_status_t status,
	input  wire logic [2:0]           in_mode,
	input  wire logic [6:0]           in_row,
	input  wire logic [8:0]           in_col,
	input  wire logic [4:0]           in_cell_value,
	input  wire logic [4:0]           cfg_states,
	input  wire logic [7:0]           cfg_rows,
	input  wire logic [9:0]           cfg_cols,
	output      logic [4:0]           read_state,
	output      logic                 op_done
);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] r, input logic [9:0] c);
		return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	logic [2:0]        mode_q;
	logic [6:0]        row_in_q;
	logic [8:0]        col_in_q;
	logic [4:0]        value_q;
	logic              bank_q;
	logic [ADDR_W-1:0] clr_q;
	logic [7:0]        row_q;
	logic [9:0]        col_q;
	logic [2:0]        ph_q;
	logic [1:0]        dr_q;
	logic [2:0]        dc_q;
	logic [4:0]        cen_q;
	logic              fire_q;
	logic [4:0]        rd_q;
	logic [ADDR_W-1:0] addr_s1;
	logic              valid_s1;

	logic [4:0]        eff_n;
	logic [7:0]        eff_r;
	logic [9:0]        eff_c;
	logic              item_inside;
	logic [ADDR_W-1:0] item_addr, sweep_addr, raddr, waddr;
	logic [7:0]        up_r, dn_r;
	logic [9:0]        lf_c, rt_c;
	logic [4:0]        rdata0, rdata1, rdata;
	logic              we_cur, we_oth, we_all, we0, we1;
	logic [4:0]        wdata;
	logic              fire;
	logic [4:0]        next_v;
	logic [8:0]        pr;
	logic [10:0]       pc;
	logic [7:0]        p_row;
	logic [9:0]        p_col;
	logic              pulse_in;
	logic              col_last, row_last;

	// saturated configuration
	always_comb begin
		if (cfg_states < emca_pkg::STATES_MIN)      eff_n = emca_pkg::STATES_MIN;
		else if (cfg_states > emca_pkg::STATES_MAX) eff_n = emca_pkg::STATES_MAX;
		else                                        eff_n = cfg_states;
		if (cfg_rows == 8'd0)                eff_r = 8'd1;
		else if (32'(cfg_rows) > MAX_ROWS)   eff_r = 8'(MAX_ROWS);
		else                                 eff_r = cfg_rows;
		if (cfg_cols == 10'd0)               eff_c = 10'd1;
		else if (32'(cfg_cols) > MAX_COLS)   eff_c = 10'(MAX_COLS);
		else                                 eff_c = cfg_cols;
	end

	assign item_inside = ({1'b0, row_in_q} < eff_r) && ({1'b0, col_in_q} < eff_c);
	assign item_addr   = cell_addr({1'b0, row_in_q}, {1'b0, col_in_q});
	assign sweep_addr  = cell_addr(row_q, col_q);
	assign col_last    = (col_q == eff_c - 10'd1);
	assign row_last    = (row_q == eff_r - 8'd1);

	// torus neighbours
	assign up_r = (row_q == 8'd0) ? eff_r - 8'd1 : row_q - 8'd1;
	assign dn_r = (row_q + 8'd1 == eff_r) ? 8'd0 : row_q + 8'd1;
	assign lf_c = (col_q == 10'd0) ? eff_c - 10'd1 : col_q - 10'd1;
	assign rt_c = (col_q + 10'd1 == eff_c) ? 10'd0 : col_q + 10'd1;

	// centre block position, offsets biased so that they stay unsigned
	assign pr       = {1'b0, eff_r >> 1} + {7'd0, dr_q};
	assign pc       = {1'b0, eff_c >> 1} + {8'd0, dc_q};
	assign p_row    = 8'(pr - {7'd0, emca_pkg::BLOCK_HALF_ROWS});
	assign p_col    = 10'(pc - {8'd0, emca_pkg::BLOCK_HALF_COLS});
	assign pulse_in = (pr >= {7'd0, emca_pkg::BLOCK_HALF_ROWS})
		&& ((pr - {7'd0, emca_pkg::BLOCK_HALF_ROWS}) < {1'b0, eff_r})
		&& (pc >= {8'd0, emca_pkg::BLOCK_HALF_COLS})
		&& ((pc - {8'd0, emca_pkg::BLOCK_HALF_COLS}) < {1'b0, eff_c});

	assign rdata  = bank_q ? rdata1 : rdata0;
	assign fire   = fire_q || (rdata == 5'd1);
	assign next_v = (cen_q == 5'd0) ? {4'd0, fire} : emca_pkg::next_cool(cen_q, eff_n);

	always_comb begin
		raddr = item_addr;
		case (cmd.act)
			emca_pkg::ACT_REST: raddr = sweep_addr;
			emca_pkg::ACT_STEP: begin
				case (ph_q)
					emca_pkg::PH_UP:    raddr = cell_addr(up_r, col_q);
					emca_pkg::PH_DOWN:  raddr = cell_addr(dn_r, col_q);
					emca_pkg::PH_LEFT:  raddr = cell_addr(row_q, lf_c);
					emca_pkg::PH_RIGHT: raddr = cell_addr(row_q, rt_c);
					default:            raddr = sweep_addr;
				endcase
			end
			default: raddr = item_addr;
		endcase
	end

	always_comb begin
		we_cur = 1'b0;
		we_oth = 1'b0;
		we_all = 1'b0;
		waddr  = item_addr;
		wdata  = 5'd0;
		// write-back of the rest sweep, in the cycle after its read
		if (valid_s1 && (rdata >= eff_n)) begin
			we_cur = 1'b1;
			waddr  = addr_s1;
		end
		case (cmd.act)
			emca_pkg::ACT_CLEAR: begin
				we_all = 1'b1;
				waddr  = clr_q;
			end
			emca_pkg::ACT_WRITE: begin
				we_cur = item_inside;
				waddr  = item_addr;
				wdata  = value_q;
			end
			emca_pkg::ACT_STEP: begin
				if (ph_q == emca_pkg::PH_WRITE) begin
					we_oth = 1'b1;
					waddr  = sweep_addr;
					wdata  = next_v;
				end
			end
			emca_pkg::ACT_PULSE: begin
				we_cur = pulse_in;
				waddr  = cell_addr(p_row, p_col);
				wdata  = 5'd1;
			end
			default: ;
		endcase
	end

	assign we0 = we_all || (bank_q ? we_oth : we_cur);
	assign we1 = we_all || (bank_q ? we_cur : we_oth);

	emca_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_bank0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata0)
	);

	emca_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_bank1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata1)
	);

	assign status.clr_last   = (32'(clr_q) == DEPTH - 1);
	assign status.sweep_last = row_last && col_last;
	assign status.step_last  = row_last && col_last && (ph_q == emca_pkg::PH_WRITE);
	assign status.pulse_last = (dr_q == emca_pkg::BLOCK_LAST_ROW)
		&& (dc_q == emca_pkg::BLOCK_LAST_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			clr_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ph_q     <= emca_pkg::PH_CENTRE;
			dr_q     <= '0;
			dc_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (cmd.act == emca_pkg::ACT_REST);
			if (cmd.zero_bank) begin
				bank_q <= 1'b0;
			end else if (cmd.flip) begin
				bank_q <= ~bank_q;
			end
			if (cmd.load) begin
				clr_q <= '0;
				row_q <= '0;
				col_q <= '0;
				ph_q  <= emca_pkg::PH_CENTRE;
				dr_q  <= '0;
				dc_q  <= '0;
			end else begin
				case (cmd.act)
					emca_pkg::ACT_CLEAR: clr_q <= clr_q + ADDR_W'(1);
					emca_pkg::ACT_REST: begin
						col_q <= col_last ? 10'd0 : col_q + 10'd1;
						if (col_last) row_q <= row_q + 8'd1;
					end
					emca_pkg::ACT_STEP: begin
						if (ph_q == emca_pkg::PH_WRITE) begin
							ph_q  <= emca_pkg::PH_CENTRE;
							col_q <= col_last ? 10'd0 : col_q + 10'd1;
							if (col_last) row_q <= row_q + 8'd1;
						end else begin
							ph_q <= ph_q + 3'd1;
						end
					end
					emca_pkg::ACT_PULSE: begin
						if (dc_q == emca_pkg::BLOCK_LAST_COL) begin
							dc_q <= '0;
							dr_q <= dr_q + 2'd1;
						end else begin
							dc_q <= dc_q + 3'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= sweep_addr;
		if (cmd.load) begin
			mode_q   <= in_mode;
			row_in_q <= in_row;
			col_in_q <= in_col;
			value_q  <= in_cell_value;
			rd_q     <= 5'd0;
		end
		if (cmd.act == emca_pkg::ACT_CAPTURE) begin
			rd_q <= item_inside ? rdata : 5'd0;
		end
		if (cmd.act == emca_pkg::ACT_STEP) begin
			if (ph_q == emca_pkg::PH_UP) begin
				cen_q  <= rdata;
				fire_q <= 1'b0;
			end else if (ph_q != emca_pkg::PH_CENTRE) begin
				fire_q <= fire;
			end
		end
		if (cmd.post) begin
			read_state <= rd_q;
			op_done    <= (mode_q <= emca_pkg::MODE_CLEAR);
		end
	end
endmodule
`default_nettype wire

// ===== src/excitable_medium_ca_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// excitable_medium_ca_engine
// Greenberg-Hastings excitable medium on a toroidal grid, APB configured.
// ----------------------------------------------------------------------------
// One request at a time; the response sits in an output register so the next
// request is taken while it waits. After reset, and for a clear request, both
// cell banks are swept to zero at one cell a cycle, and no request is taken
// while the sweep runs. A generation step reads each active cell and its four
// neighbours through the single read port of the source bank and writes the
// other bank. Resting overflow sweeps the R*C active cells, its last write-back
// landing in the done state; the centre pulse writes its 3x7 block and a read
// passes through a read and a capture state. Every request is accepted in idle
// and posts its response from the done state once the output register is
// free.
module excitable_medium_ca_engine #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	emca_req_if.sink         req,
	emca_rsp_if.source       rsp
);
	logic [4:0]           states_q;
	logic [7:0]           rows_q;
	logic [9:0]           cols_q;
	logic                 cfg_wr;
	emca_pkg::dp_cmd_t    cmd;
	emca_pkg::dp_status_t status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_q <= emca_pkg::STATES_RESET;
			rows_q   <= emca_pkg::ROWS_RESET;
			cols_q   <= emca_pkg::COLS_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				emca_pkg::REG_NUM_STATES: states_q <= pwdata[4:0];
				emca_pkg::REG_ROWS:       rows_q   <= pwdata[7:0];
				emca_pkg::REG_COLS:       cols_q   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			emca_pkg::REG_NUM_STATES: prdata = {27'd0, states_q};
			emca_pkg::REG_ROWS:       prdata = {24'd0, rows_q};
			emca_pkg::REG_COLS:       prdata = {22'd0, cols_q};
			default:                  prdata = 32'd0;
		endcase
	end

	emca_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_mode(req.mode), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.status(status), .cmd(cmd)
	);

	emca_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_mode(req.mode), .in_row(req.row), .in_col(req.col),
		.in_cell_value(req.cell_value),
		.cfg_states(states_q), .cfg_rows(rows_q), .cfg_cols(cols_q),
		.read_state(rsp.read_state), .op_done(rsp.op_done)
	);

	// a posted result never overwrites one still waiting
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> (!rsp.valid || rsp.ready))
		else $error("result posted over a pending one");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (req.valid && req.ready))
		else $error("item latched without a request");

	a_flip_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flip |-> (status.step_last && cmd.act == emca_pkg::ACT_STEP))
		else $error("bank flipped before the last cell was written");

	a_done_follows_post: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |=> rsp.valid)
		else $error("posted result not presented");
endmodule
`default_nettype wire

// ===== bench/excitable_medium_ca_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// excitable_medium_ca_engine_tb
// Drives grid operations through the request channel and APB register writes
// over several grid sizes and state counts, predicts every response from a
// local copy of both cell banks, and checks each response in order.
// ----------------------------------------------------------------------------
module excitable_medium_ca_engine_tb;

	localparam int GRID_ROWS = 128;
	localparam int GRID_COLS = 512;
	localparam int BANK_SIZE = GRID_ROWS * GRID_COLS;
	localparam int IDLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	typedef struct {
		logic [4:0] read_state;
		logic       op_done;
	} resp_t;

	typedef struct {
		logic [2:0] mode;
		logic [6:0] row;
		logic [8:0] col;
		logic [4:0] val;
		bit         typed;
		logic [4:0] rd;
		logic       done;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	emca_req_if req ();
	emca_rsp_if rsp ();

	excitable_medium_ca_engine DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req), .rsp(rsp)
	);

	// local copy of the block
	logic [4:0] cells [0:2*BANK_SIZE-1];
	logic       cur_bank;
	logic [4:0] cfg_states;
	logic [7:0] cfg_rows;
	logic [9:0] cfg_cols;

	resp_t pending_resp [$];
	int    mismatches = 0;
	int    resp_seen = 0;
	int    reqs_sent = 0;
	int    steps_sent = 0;
	int    clears_sent = 0;
	int    tx_idle_pct = 0;
	int    rx_idle_pct = 0;
	int    hold_trigger = 0;
	int    idle_cycles = 0;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic int n_eff();
		if (cfg_states < emca_pkg::STATES_MIN) return emca_pkg::STATES_MIN;
		if (cfg_states > emca_pkg::STATES_MAX) return emca_pkg::STATES_MAX;
		return cfg_states;
	endfunction

	function automatic int rows_eff();
		if (cfg_rows < 1) return 1;
		if (cfg_rows > GRID_ROWS) return GRID_ROWS;
		return cfg_rows;
	endfunction

	function automatic int cols_eff();
		if (cfg_cols < 1) return 1;
		if (cfg_cols > GRID_COLS) return GRID_COLS;
		return cfg_cols;
	endfunction

	function automatic int idx(logic b, int r, int c);
		return int'(b) * BANK_SIZE + r * GRID_COLS + c;
	endfunction

	function automatic void wipe_grid();
		for (int k = 0; k < 2 * BANK_SIZE; k++) cells[k] = 5'd0;
		cur_bank = 1'b0;
	endfunction

	function automatic void advance_generation();
		int n, nr, nc, up, dn, lf, rt, s;
		logic src;
		n = n_eff(); nr = rows_eff(); nc = cols_eff();
		src = cur_bank;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				s = cells[idx(src, r, c)];
				if (s == 0) begin
					up = (r == 0) ? nr - 1 : r - 1;
					dn = (r + 1 == nr) ? 0 : r + 1;
					lf = (c == 0) ? nc - 1 : c - 1;
					rt = (c + 1 == nc) ? 0 : c + 1;
					cells[idx(~src, r, c)] = (cells[idx(src, up, c)] == 1 ||
						cells[idx(src, dn, c)] == 1 || cells[idx(src, r, lf)] == 1 ||
						cells[idx(src, r, rt)] == 1) ? 5'd1 : 5'd0;
				end else begin
					cells[idx(~src, r, c)] = 5'((s + 1) % n);
				end
			end
		end
		cur_bank = ~src;
	endfunction

	function automatic resp_t predict_grid_op(logic [2:0] mode, logic [6:0] row,
			logic [8:0] col, logic [4:0] val);
		resp_t o;
		bit in_area;
		int nr, nc, r, c;
		nr = rows_eff(); nc = cols_eff();
		in_area = (row < nr) && (col < nc);
		o.read_state = 5'd0;
		o.op_done = 1'b1;
		case (mode)
			emca_pkg::MODE_WRITE: if (in_area) cells[idx(cur_bank, row, col)] = val;
			emca_pkg::MODE_READ: if (in_area) o.read_state = cells[idx(cur_bank, row, col)];
			emca_pkg::MODE_STEP: advance_generation();
			emca_pkg::MODE_PULSE: begin
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -3; dc <= 3; dc++) begin
						r = nr / 2 + dr;
						c = nc / 2 + dc;
						if (r >= 0 && r < nr && c >= 0 && c < nc)
							cells[idx(cur_bank, r, c)] = 5'd1;
					end
			end
			emca_pkg::MODE_REST: begin
				for (int rr = 0; rr < nr; rr++)
					for (int cc = 0; cc < nc; cc++)
						if (cells[idx(cur_bank, rr, cc)] >= n_eff())
							cells[idx(cur_bank, rr, cc)] = 5'd0;
			end
			emca_pkg::MODE_CLEAR: wipe_grid();
			default: o.op_done = 1'b0;
		endcase
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: response %0d %s got %0d expected %0d",
			$realtime, resp_seen, what, got, want);
		mismatches++;
	endtask

	task automatic apb_write(logic [1:0] regno, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {regno, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		case (regno)
			emca_pkg::REG_NUM_STATES: cfg_states = value[4:0];
			emca_pkg::REG_ROWS: cfg_rows = value[7:0];
			default: cfg_cols = value[9:0];
		endcase
	endtask

	task automatic configure(logic [4:0] n, logic [7:0] r, logic [9:0] c);
		apb_write(emca_pkg::REG_NUM_STATES, 32'(n));
		apb_write(emca_pkg::REG_ROWS, 32'(r));
		apb_write(emca_pkg::REG_COLS, 32'(c));
	endtask

	task automatic drain();
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one request; the predictor runs at acceptance, so order matches the block
	task automatic send_op(logic [2:0] mode, logic [6:0] row, logic [8:0] col,
			logic [4:0] val, bit typed, logic [4:0] rd, logic done);
		int gap;
		resp_t o;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= mode; req.row <= row; req.col <= col; req.cell_value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		o = predict_grid_op(mode, row, col, val);
		if (typed) begin
			o.read_state = rd;
			o.op_done = done;
		end
		pending_resp.push_back(o);
		reqs_sent++;
		if (mode == emca_pkg::MODE_STEP) steps_sent++;
		if (mode == emca_pkg::MODE_CLEAR) clears_sent++;
	endtask

	task automatic send_random();
		int pick;
		logic [2:0] mode;
		logic [6:0] row;
		logic [8:0] col;
		pick = $urandom_range(99);
		if (pick < 35) mode = emca_pkg::MODE_WRITE;
		else if (pick < 70) mode = emca_pkg::MODE_READ;
		else if (pick < 85) mode = emca_pkg::MODE_STEP;
		else if (pick < 90) mode = emca_pkg::MODE_PULSE;
		else if (pick < 95) mode = emca_pkg::MODE_REST;
		else if (pick < 97 && clears_sent < 3) mode = emca_pkg::MODE_CLEAR;
		else mode = ($urandom_range(1)) ? MODE_SPARE_A : MODE_SPARE_B;
		// mostly inside the active area, the rest anywhere
		if ($urandom_range(9) < 7) begin
			row = 7'($urandom_range(rows_eff() - 1));
			col = 9'($urandom_range(cols_eff() - 1));
		end else begin
			row = 7'($urandom);
			col = 9'($urandom);
		end
		send_op(mode, row, col, 5'($urandom), 1'b0, 5'd0, 1'b0);
	endtask

	// response checker
	always @(posedge clk) begin
		resp_t w;
		if (rsp.valid && rsp.ready) begin
			if (pending_resp.size() == 0) begin
				report("with nothing pending", rsp.read_state, 0);
			end else begin
				w = pending_resp.pop_front();
				if (rsp.read_state !== w.read_state)
					report("read_state", rsp.read_state, w.read_state);
				if (rsp.op_done !== w.op_done)
					report("op_done", rsp.op_done, w.op_done);
			end
			resp_seen++;
		end
	end

	// response side back-pressure, with a long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		int hold_seen;
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired with %0d responses pending", pending_resp.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	dir_row_t dir_tab [] = '{
		'{emca_pkg::MODE_READ,  7'd0,   9'd0,   5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd127, 9'd511, 5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_WRITE, 7'd0,   9'd0,   5'd31, 1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd0,   9'd0,   5'd0,  1, 5'd31, 1'b1},
		'{emca_pkg::MODE_WRITE, 7'd127, 9'd511, 5'd19, 1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd127, 9'd511, 5'd0,  1, 5'd19, 1'b1},
		'{emca_pkg::MODE_WRITE, 7'd5,   9'd5,   5'd12, 0, 5'd0,  1'b0},
		'{MODE_SPARE_A,         7'd1,   9'd1,   5'd1,  1, 5'd0,  1'b0},
		'{MODE_SPARE_B,         7'd0,   9'd0,   5'd0,  1, 5'd0,  1'b0},
		'{emca_pkg::MODE_PULSE, 7'd0,   9'd0,   5'd0,  0, 5'd0,  1'b0},
		'{emca_pkg::MODE_READ,  7'd64,  9'd256, 5'd0,  1, 5'd1,  1'b1},
		'{emca_pkg::MODE_READ,  7'd65,  9'd259, 5'd0,  1, 5'd1,  1'b1},
		'{emca_pkg::MODE_READ,  7'd66,  9'd260, 5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_REST,  7'd0,   9'd0,   5'd0,  0, 5'd0,  1'b0},
		'{emca_pkg::MODE_READ,  7'd0,   9'd0,   5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd127, 9'd511, 5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd5,   9'd5,   5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_WRITE, 7'd1,   9'd1,   5'd11, 0, 5'd0,  1'b0},
		'{emca_pkg::MODE_READ,  7'd1,   9'd1,   5'd0,  0, 5'd0,  1'b0},
		'{emca_pkg::MODE_CLEAR, 7'd0,   9'd0,   5'd0,  0, 5'd0,  1'b0},
		'{emca_pkg::MODE_READ,  7'd1,   9'd1,   5'd0,  1, 5'd0,  1'b1},
		'{emca_pkg::MODE_READ,  7'd64,  9'd256, 5'd0,  1, 5'd0,  1'b1}
	};

	// grid settings per random phase: states, rows, columns (some out of range)
	logic [4:0] ph_states [7] = '{5'd5, 5'd20, 5'd3, 5'd31, 5'd12, 5'd7, 5'd9};
	logic [7:0] ph_rows   [7] = '{8'd1, 8'd4, 8'd0, 8'd8, 8'd3, 8'd200, 8'd6};
	logic [9:0] ph_cols   [7] = '{10'd1, 10'd9, 10'd7, 10'd16, 10'd0, 10'd3, 10'd1000};

	initial begin
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.mode = emca_pkg::MODE_WRITE; req.row = '0; req.col = '0;
		req.cell_value = '0;
		cfg_states = emca_pkg::STATES_RESET;
		cfg_rows = emca_pkg::ROWS_RESET;
		cfg_cols = emca_pkg::COLS_RESET;
		wipe_grid();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 25; rx_idle_pct = 81;
		foreach (dir_tab[i])
			send_op(dir_tab[i].mode, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
				dir_tab[i].typed, dir_tab[i].rd, dir_tab[i].done);
		req.valid <= 1'b0;

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			configure(ph_states[ph], ph_rows[ph], ph_cols[ph]);
			if (ph == 3) begin
				tx_idle_pct = 81; rx_idle_pct = 25;
			end else if (ph == 5) begin
				tx_idle_pct = 0; rx_idle_pct = 0;
				hold_trigger++;
			end
			repeat (14) send_random();
			req.valid <= 1'b0;
		end
		drain();
		configure(emca_pkg::STATES_RESET, emca_pkg::ROWS_RESET, emca_pkg::COLS_RESET);

		drain();
		repeat (50) @(posedge clk);
		$display("Ran %0d requests, %0d responses, %0d generation steps, %0d clears",
			reqs_sent, resp_seen, steps_sent, clears_sent);
		$display("Covered 7 grid settings, saturated registers and tiny wrapped grids");
		if (mismatches == 0 && pending_resp.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/emca_pkg.sv
src/emca_req_if.sv
src/emca_rsp_if.sv
src/emca_ram.sv
src/emca_ctrl.sv
src/emca_dp.sv
src/excitable_medium_ca_engine.sv
bench/excitable_medium_ca_engine_tb.sv
